// ----- hdl/ilstk_pkg.sv -----
package ilstk_pkg;

	localparam int CMD_W = 3;
	localparam int WORD_W = 32;
	localparam int IDX_W = 5;
	localparam int STAT_W = 2;
	// wide enough for any cell position or fill count up to 1024 words
	localparam int POS_W = 11;

	localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DROP = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic signed [WORD_W-1:0] push_value;
		logic [IDX_W-1:0] index;
	} in_beat_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_value;
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0] count;
		logic [IDX_W-1:0] removed;
	} out_beat_t;

	typedef struct packed {
		logic wr_en;
		logic sh_en;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] cnt;
		logic [POS_W-1:0] rd_pos;
	} cell_ctl_t;

endpackage

// ----- hdl/indexed_lifo_stack_top.sv -----
// Bounded LIFO stack with indexed peek, remove-at and multi-word drop. One command
// is taken on every clock where start is high; busy never rises, and the result is
// strobed on done for exactly one cycle, the cycle right after the command. The
// words sit in a row of cells, one per slot from the bottom; a push loads the cell
// at the fill count, a remove-at makes the hole's cell and each cell above it but the
// top take its upper neighbor's word in the same cycle, and a read picks one cell
// by a one-hot match ORed across the row. Drop only moves the fill count. Results
// cannot be held off, so the receiver must sample every done beat.
module indexed_lifo_stack_top
	import ilstk_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int ITEM_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input in_beat_t request,
	output logic done,
	output out_beat_t result
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int EXT_W = (ITEM_WIDTH > WORD_W) ? ITEM_WIDTH : WORD_W;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nxt;
	logic done_q;
	out_beat_t res_q;
	out_beat_t res_nxt;

	logic fire;
	logic full;
	logic empty;
	logic idx_ok;
	logic [CMP_W-1:0] cnt_e;
	logic [CMP_W-1:0] idx_e;
	logic [CMP_W-1:0] top_pos;
	logic [CMP_W-1:0] sel_pos;
	logic [CMP_W-1:0] take;

	logic signed [EXT_W-1:0] push_ext;
	logic [ITEM_WIDTH-1:0] push_item;
	logic signed [ITEM_WIDTH-1:0] rd_or;
	logic signed [EXT_W-1:0] rd_ext;
	logic signed [WORD_W-1:0] rd_value;

	logic [ITEM_WIDTH-1:0] items [DEPTH];
	logic [ITEM_WIDTH-1:0] rd_items [DEPTH];
	cell_ctl_t ctl;

	assign busy = 1'b0;
	assign fire = start && !busy;

	assign cnt_e = CMP_W'(cnt_q);
	assign idx_e = CMP_W'(request.index);
	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign idx_ok = (idx_e < cnt_e);
	assign top_pos = cnt_e - CMP_W'(1);
	assign sel_pos = (request.cmd == CMD_POP) ? top_pos : (top_pos - idx_e);
	assign take = idx_ok ? idx_e : cnt_e;

	assign push_ext = EXT_W'(request.push_value);
	assign push_item = push_ext[ITEM_WIDTH-1:0];

	always_comb begin
		ctl.wr_en = fire && request.cmd == CMD_PUSH && !full;
		ctl.sh_en = fire && request.cmd == CMD_REMOVE && idx_ok;
		ctl.pos = (request.cmd == CMD_PUSH) ? POS_W'(cnt_q) : POS_W'(sel_pos);
		ctl.cnt = POS_W'(cnt_q);
		ctl.rd_pos = POS_W'(sel_pos);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ITEM_WIDTH-1:0] up_item;

		if (i == DEPTH - 1) begin : g_last
			assign up_item = '0;
		end else begin : g_mid
			assign up_item = items[i+1];
		end

		ilstk_cell #(
			.ITEM_WIDTH(ITEM_WIDTH),
			.POS(i)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.push_item(push_item),
			.up_item(up_item),
			.item(items[i]),
			.rd_item(rd_items[i])
		);
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | rd_items[i];
		end
	end

	assign rd_ext = EXT_W'(rd_or);
	assign rd_value = rd_ext[WORD_W-1:0];

	always_comb begin
		cnt_nxt = cnt_q;
		res_nxt.read_value = '0;
		res_nxt.status = ST_OK;
		res_nxt.removed = '0;
		case (request.cmd)
			CMD_PUSH: begin
				if (full) begin
					res_nxt.status = ST_FULL;
				end else begin
					cnt_nxt = cnt_q + CNT_W'(1);
				end
			end
			CMD_POP: begin
				if (empty) begin
					res_nxt.status = ST_MISS;
				end else begin
					cnt_nxt = cnt_q - CNT_W'(1);
					res_nxt.read_value = rd_value;
				end
			end
			CMD_PEEK: begin
				if (!idx_ok) begin
					res_nxt.status = ST_MISS;
				end else begin
					res_nxt.read_value = rd_value;
				end
			end
			CMD_REMOVE: begin
				if (!idx_ok) begin
					res_nxt.status = ST_MISS;
				end else begin
					cnt_nxt = cnt_q - CNT_W'(1);
					res_nxt.read_value = rd_value;
				end
			end
			CMD_DROP: begin
				cnt_nxt = CNT_W'(cnt_e - take);
				res_nxt.removed = IDX_W'(take);
			end
			default: begin
				cnt_nxt = cnt_q;
			end
		endcase
		res_nxt.count = IDX_W'(cnt_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= fire;
			if (fire) begin
				cnt_q <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_nxt;
		end
	end

	assign done = done_q;
	assign result = res_q;

endmodule

// ----- hdl/ilstk_cell.sv -----
module ilstk_cell
	import ilstk_pkg::*;
#(
	parameter int ITEM_WIDTH = 32,
	parameter int POS = 0
) (
	input logic clk,
	input cell_ctl_t ctl,
	input logic [ITEM_WIDTH-1:0] push_item,
	input logic [ITEM_WIDTH-1:0] up_item,
	output logic [ITEM_WIDTH-1:0] item,
	output logic [ITEM_WIDTH-1:0] rd_item
);

	localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);
	localparam logic [POS_W-1:0] NEXT_POS = POS_W'(POS + 1);

	logic [ITEM_WIDTH-1:0] item_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en && ctl.pos == MY_POS) begin
			item_q <= push_item;
		end else if (ctl.sh_en && MY_POS >= ctl.pos && NEXT_POS < ctl.cnt) begin
			item_q <= up_item;
		end
	end

	assign item = item_q;
	assign rd_item = (ctl.rd_pos == MY_POS) ? item_q : '0;

endmodule

// ----- hdl/ilstk_chk.sv -----
module ilstk_chk
	import ilstk_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input in_beat_t request,
	input logic done,
	input out_beat_t result
);

	// one result beat per accepted command, in the next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("missing result beat");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result beat without command");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |-> (result.count == IDX_W'(DEPTH)))
		else $error("full status with stack not full");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.read_value == '0))
		else $error("nonzero word on failed command");

	a_removed_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.cmd != CMD_DROP) |=> (result.removed == '0))
		else $error("removed count on non-drop command");

endmodule

bind indexed_lifo_stack_top ilstk_chk #(
	.DEPTH(DEPTH)
) u_ilstk_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.request(request),
	.done(done),
	.result(result)
);
